/* design/utd_pkg.sv */
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

   // Work item handed from the front end to the back end through the queue
   typedef struct packed {
      logic [20:0] code_point;   // decoded value, at most 0x10ffff
      logic        pair;         // value needs a surrogate pair
      logic        fin;          // byte was the final byte of the string
      logic        err;          // string was malformed
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   localparam logic [30:0] MAX_CODE_POINT = 31'h10ffff;
   localparam logic [20:0] MAX_BMP        = 21'h00ffff;
   localparam logic [20:0] SUPP_BASE      = 21'h010000;
   localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;   // 0xd800 >> 10
   localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;   // 0xdc00 >> 10

endpackage

/* design/utf8_to_utf16_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream to UTF-16 code unit stream transcoder.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one UTF-8 byte per item, req_string_end marks the final byte.
//   rsp_*  : one UTF-16 code unit per item; a supplementary character gives
//            the high half and then the low half. rsp_run_last marks the
//            last unit caused by one byte, rsp_at_string_end the last unit
//            of a string. A malformed string ends in one item with
//            rsp_decode_error set and code unit zero; units sent earlier for
//            that string are to be dropped by the receiver.
//   A byte that completes a unit is written into the queue when accepted,
//   and the unit is then loaded from the queue head into the output register.
//   Throughput: one byte per cycle while the queue is not full; the halves
//   of a surrogate pair share the single output register of the back end,
//   and QUEUE_DEPTH queue items absorb that, as a pair needs four bytes.
//   Reset: synchronous; clears the sequence state, the queue and the output valid.
//   When the receiver stalls the output holds, the queue fills, and
//   req_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_at_string_end,
   output logic        rsp_decode_error,
   output logic        rsp_run_last
);

   logic               queue_full;
   logic               queue_not_empty;
   logic               push;
   logic               pop;
   utd_pkg::entry_type push_entry;
   utd_pkg::entry_type head_entry;

   // Decode bytes into work items
   utd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Decouple front and back
   utd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   // Emit code units
   utd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .not_empty         (queue_not_empty),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_at_string_end (rsp_at_string_end),
      .rsp_decode_error  (rsp_decode_error),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

/* design/utd_front.sv */
// ----------------------------------------------------------------------------
// utd_front
// Front end: accepts bytes, tracks the multibyte sequence and queues one
// work item for each byte that completes a character or ends a bad string.
// ----------------------------------------------------------------------------
module utd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_string_end,
   input  logic                queue_full,
   output logic                push,
   output utd_pkg::entry_type  push_entry
);

   localparam logic [1:0] PH_LEAD    = 2'd0;
   localparam logic [1:0] PH_CONT    = 2'd1;
   localparam logic [1:0] PH_DISCARD = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  pend_ff, pend_in;
   logic [30:0] acc_ff, acc_in;

   logic        fire;
   logic        err;
   logic        done;
   logic        lead_bad;
   logic [30:0] val;
   logic [30:0] acc_next;
   logic [2:0]  pend_next;
   logic [6:0]  lead_val;
   logic [2:0]  extra;

   assign req_ready = !queue_full;
   assign fire      = req_valid && req_ready;

   // Classify a lead byte
   always_comb begin
      lead_bad = 1'b0;
      lead_val = 7'd0;
      extra    = 3'd0;
      if ((req_data_byte & 8'hfc) == 8'hfc) begin
         lead_val = {6'd0, req_data_byte[0]};
         extra    = 3'd5;
      end else if ((req_data_byte & 8'hf8) == 8'hf8) begin
         lead_val = {5'd0, req_data_byte[1:0]};
         extra    = 3'd4;
      end else if ((req_data_byte & 8'hf0) == 8'hf0) begin
         lead_val = {4'd0, req_data_byte[2:0]};
         extra    = 3'd3;
      end else if ((req_data_byte & 8'he0) == 8'he0) begin
         lead_val = {3'd0, req_data_byte[3:0]};
         extra    = 3'd2;
      end else if ((req_data_byte & 8'hc0) == 8'hc0) begin
         lead_val = {2'd0, req_data_byte[4:0]};
         extra    = 3'd1;
      end else if (!req_data_byte[7]) begin
         lead_val = req_data_byte[6:0];
         extra    = 3'd0;
      end else begin
         lead_bad = 1'b1;
      end
   end

   // Advance the sequence state for the byte on the port
   always_comb begin
      acc_next  = {acc_ff[24:0], req_data_byte[5:0]};
      pend_next = pend_ff - 3'd1;
      err       = 1'b0;
      done      = 1'b0;
      val       = 31'd0;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      case (phase_ff)
         PH_LEAD: begin
            if (lead_bad) begin
               err = 1'b1;
            end else if (extra == 3'd0) begin
               done = 1'b1;
               val  = {24'd0, lead_val};
            end else begin
               phase_in = PH_CONT;
               pend_in  = extra;
               acc_in   = {24'd0, lead_val};
            end
         end
         PH_CONT: begin
            if (req_data_byte[7]) begin
               acc_in  = acc_next;
               pend_in = pend_next;
               if (pend_next == 3'd0) begin
                  done = 1'b1;
                  val  = acc_next;
               end
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            err = 1'b1;
         end
      endcase

      if (done && (val > utd_pkg::MAX_CODE_POINT)) begin
         err = 1'b1;
      end
      if (!err && !done && req_string_end) begin
         err = 1'b1;
      end

      // Errors and finished characters drop all sequence state
      if (err) begin
         phase_in = req_string_end ? PH_LEAD : PH_DISCARD;
         pend_in  = 3'd0;
         acc_in   = 31'd0;
      end else if (done) begin
         phase_in = PH_LEAD;
         pend_in  = 3'd0;
         acc_in   = 31'd0;
      end
   end

   // Queue an item for a finished character or a bad string's final byte
   always_comb begin
      push                  = fire && ((err && req_string_end) || (!err && done));
      push_entry.code_point = val[20:0];
      push_entry.pair       = !err && (val[20:0] > utd_pkg::MAX_BMP);
      push_entry.fin        = req_string_end;
      push_entry.err        = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         pend_ff  <= 3'd0;
         acc_ff   <= 31'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

/* design/utd_fifo.sv */
// ----------------------------------------------------------------------------
// utd_fifo
// Short queue of work items between the front end and the back end.
// ----------------------------------------------------------------------------
module utd_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utd_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output utd_pkg::entry_type  head_entry
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   utd_pkg::entry_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store item payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/utd_back.sv */
// ----------------------------------------------------------------------------
// utd_back
// Back end: turns queued work items into UTF-16 code units, splitting
// supplementary values into two halves, and holds them in the output register.
// ----------------------------------------------------------------------------
module utd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  utd_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_code_unit,
   output logic                rsp_at_string_end,
   output logic                rsp_decode_error,
   output logic                rsp_run_last
);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic [15:0] unit_ff, unit_in;
   logic        end_ff, end_in;
   logic        err_ff, err_in;
   logic        last_ff, last_in;

   logic        load;
   logic [20:0] offset;

   assign load   = not_empty && (!valid_ff || rsp_ready);
   assign offset = head_entry.code_point - utd_pkg::SUPP_BASE;

   // Pick the next code unit from the head item
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      half_in  = half_ff;
      unit_in  = unit_ff;
      end_in   = end_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_entry.err) begin
            unit_in = 16'd0;
            end_in  = 1'b1;
            err_in  = 1'b1;
            last_in = 1'b1;
            pop     = 1'b1;
         end else if (head_entry.pair && !half_ff) begin
            unit_in = {utd_pkg::HIGH_SURR_TAG, offset[19:10]};
            end_in  = 1'b0;
            err_in  = 1'b0;
            last_in = 1'b0;
            half_in = 1'b1;
         end else if (head_entry.pair) begin
            unit_in = {utd_pkg::LOW_SURR_TAG, offset[9:0]};
            end_in  = head_entry.fin;
            err_in  = 1'b0;
            last_in = 1'b1;
            half_in = 1'b0;
            pop     = 1'b1;
         end else begin
            unit_in = head_entry.code_point[15:0];
            end_in  = head_entry.fin;
            err_in  = 1'b0;
            last_in = 1'b1;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   // Hold the result payload until it is taken
   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      end_ff  <= end_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_code_unit     = unit_ff;
   assign rsp_at_string_end = end_ff;
   assign rsp_decode_error  = err_ff;
   assign rsp_run_last      = last_ff;

endmodule

/* design/utd_checker.sv */
// ----------------------------------------------------------------------------
// utd_checker
// Port-level checks of the decoder's result stream.
// ----------------------------------------------------------------------------
module utd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_at_string_end,
   input logic        rsp_decode_error,
   input logic        rsp_run_last
);

   // Hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit)
         && $stable(rsp_run_last))
      else $error("stalled result item changed");

   // Error item closes the string with a zero unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_error |->
         rsp_at_string_end && rsp_run_last && (rsp_code_unit == 16'd0))
      else $error("error item malformed");

   // String end is always the last unit of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_string_end |-> rsp_run_last)
      else $error("string end without run end");

   // Only a high surrogate precedes another unit of the same byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_code_unit[15:10] == utd_pkg::HIGH_SURR_TAG)
      else $error("non-final unit is not a high surrogate");

   // High half is followed by the low half once taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last ##1 rsp_valid |->
         rsp_code_unit[15:10] == utd_pkg::LOW_SURR_TAG)
      else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_decoder utd_checker u_utd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_code_unit     (rsp_code_unit),
   .rsp_at_string_end (rsp_at_string_end),
   .rsp_decode_error  (rsp_decode_error),
   .rsp_run_last      (rsp_run_last)
);
